// ----- src/ordered_array_list_engine_defines.svh -----
// Assertion macros for the ordered array list engine.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define OALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/oale_pkg.sv -----
// Shared types and constants for the ordered array list engine.
// No dependencies.
package oale_pkg;

  localparam int unsigned DEPTH_DEF = 64;   // list capacity; field widths allow up to 64
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned FIDX_W    = 6;
  localparam int unsigned STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd6;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [CNT_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [FIDX_W-1:0] found_index;
    logic [CNT_W-1:0]  count;
  } result_t;

  typedef enum logic [1:0] {
    PLAN_NOW,   // ignored or full: answered at once
    PLAN_INS,
    PLAN_ERA,
    PLAN_FIND
  } plan_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DN,
    S_SCAN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic              load;
    logic              step_up;
    logic              step_dn;
    logic              step_scan;
    logic              put;
    logic              finish;
    logic              inc;
    logic              dec;
    logic              found;
    logic [STAT_W-1:0] status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    plan_e             plan;
    logic [STAT_W-1:0] imm_status;
    logic              up_more;
    logic              dn_more;
    logic              scan_more;
    logic              chk;
    logic              hit;
  } sts_t;

endpackage

// ----- src/oale_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oale_ram #(
  parameter  int unsigned WIDTH  = 32,
  parameter  int unsigned DEPTH  = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/oale_ctrl.sv -----
// Sequencer for the ordered array list engine.
// Depends on oale_pkg and the assertion macro header.
`include "ordered_array_list_engine_defines.svh"

module oale_ctrl
  import oale_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (sts_i.plan)
            PLAN_INS:  state_d = S_UP;
            PLAN_ERA:  state_d = S_DN;
            PLAN_FIND: state_d = S_SCAN;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_UP: begin
        if (!sts_i.up_more) begin
          state_d = S_PUT;
        end
      end
      S_PUT: state_d = S_IDLE;
      S_DN: begin
        if (!sts_i.dn_more) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.hit || (!sts_i.scan_more && !sts_i.chk)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (sts_i.plan == PLAN_NOW) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = sts_i.imm_status;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_UP: begin
        cmd_o.step_up = sts_i.up_more;
      end
      S_PUT: begin
        cmd_o.put    = 1'b1;
        cmd_o.finish = 1'b1;
        cmd_o.inc    = 1'b1;
      end
      S_DN: begin
        if (sts_i.dn_more) begin
          cmd_o.step_dn = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.dec    = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.found  = 1'b1;
        end else if (sts_i.scan_more) begin
          cmd_o.step_scan = 1'b1;
        end else if (!sts_i.chk) begin
          cmd_o.finish = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  `OALE_ASSERT_NEXT(a_finish_idles, cmd_o.finish, state_q == S_IDLE, "finish not followed by idle")
  `OALE_ASSERT_NOW(a_load_only_idle, cmd_o.load, !busy_o && start_i, "load outside accept")

endmodule

// ----- src/oale_dp.sv -----
// Datapath: entry store, cursor, pending move, compare and result register.
// Depends on oale_pkg, oale_ram and the assertion macro header.
`include "ordered_array_list_engine_defines.svh"

module oale_dp
  import oale_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output sts_t    sts_o,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_q, pend_d;
  logic             chk_q, chk_d;
  logic             done_q;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] wdst_q, wdst_d;
  logic [CNT_W-1:0] chk_idx_q, chk_idx_d;
  logic [VAL_W-1:0] val_q;
  result_t          res_q, res_d;

  // decode of a new item
  logic [CNT_W-1:0]  eff_pos;
  plan_e             plan;
  logic [STAT_W-1:0] imm_status;

  always_comb begin
    eff_pos    = item_i.position;
    plan       = PLAN_NOW;
    imm_status = STAT_IGNORED;
    case (item_i.operation)
      OP_PUSH_BACK:  eff_pos = count_q;
      OP_PUSH_FRONT: eff_pos = '0;
      OP_POP_BACK:   eff_pos = count_q - CNT_W'(1);  // wraps high on empty list
      OP_POP_FRONT:  eff_pos = '0;
      default:       eff_pos = item_i.position;
    endcase
    case (item_i.operation)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (eff_pos > count_q) begin
          imm_status = STAT_IGNORED;
        end else if (count_q >= CapCnt) begin
          imm_status = STAT_FULL;
        end else begin
          plan = PLAN_INS;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_ERASE: begin
        if (eff_pos < count_q) begin
          plan = PLAN_ERA;
        end
      end
      OP_FIND: plan = PLAN_FIND;
      default: plan = PLAN_NOW;
    endcase
  end

  // entry store
  logic              ram_we, ram_re;
  logic [CNT_W-1:0]  ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  assign ram_we    = cmd_i.put || pend_q;
  assign ram_waddr = cmd_i.put ? pos_q : wdst_q;
  assign ram_wdata = cmd_i.put ? val_q : ram_rdata;
  assign ram_re    = cmd_i.step_up || cmd_i.step_dn || cmd_i.step_scan;
  assign ram_raddr = cmd_i.step_up ? (cur_q - CNT_W'(1)) : cur_q;

  oale_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr[ADDR_W-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // cursor and pending move
  always_comb begin
    pos_d     = pos_q;
    cur_d     = cur_q;
    wdst_d    = wdst_q;
    chk_idx_d = chk_idx_q;
    pend_d    = 1'b0;
    chk_d     = 1'b0;
    if (cmd_i.load) begin
      pos_d = eff_pos;
      case (plan)
        PLAN_INS: cur_d = count_q;
        PLAN_ERA: cur_d = eff_pos + CNT_W'(1);
        default:  cur_d = '0;
      endcase
    end else if (cmd_i.step_up) begin
      pend_d = 1'b1;
      wdst_d = cur_q;
      cur_d  = cur_q - CNT_W'(1);
    end else if (cmd_i.step_dn) begin
      pend_d = 1'b1;
      wdst_d = cur_q - CNT_W'(1);
      cur_d  = cur_q + CNT_W'(1);
    end else if (cmd_i.step_scan) begin
      chk_d     = 1'b1;
      chk_idx_d = cur_q;
      cur_d     = cur_q + CNT_W'(1);
    end
  end

  // count and result
  always_comb begin
    count_d = count_q;
    if (cmd_i.inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CNT_W'(1);
    end
    res_d             = res_q;
    res_d.status      = cmd_i.status;
    res_d.found       = cmd_i.found;
    res_d.found_index = cmd_i.found ? chk_idx_q[FIDX_W-1:0] : '0;
    res_d.count       = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      chk_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
      chk_q   <= chk_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    wdst_q    <= wdst_d;
    chk_idx_q <= chk_idx_d;
    if (cmd_i.load) begin
      val_q <= item_i.value;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign sts_o.plan       = plan;
  assign sts_o.imm_status = imm_status;
  assign sts_o.up_more    = (cur_q > pos_q);
  assign sts_o.dn_more    = (cur_q < count_q);
  assign sts_o.scan_more  = (cur_q < count_q);
  assign sts_o.chk        = chk_q;
  assign sts_o.hit        = chk_q && (ram_rdata == val_q);

  assign done_o   = done_q;
  assign result_o = res_q;

  `OALE_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CapCnt, "entry count above capacity")
  `OALE_ASSERT_NOW(a_one_writer, cmd_i.put, !pend_q, "value write collides with shift write")
  `OALE_ASSERT_NEXT(a_inc_grows, cmd_i.inc, count_q == $past(count_q) + CNT_W'(1),
                    "count did not grow on insert")

endmodule

// ----- src/ordered_array_list_engine.sv -----
// Top level of the ordered array list engine: controller plus datapath.
// Depends on oale_pkg, oale_ctrl and oale_dp (which holds oale_ram).
//
//  channel  | strobe / hold   | payload
//  ---------+-----------------+-----------------------------------------
//  item in  | start_i, busy_o | item_i   (operation, position, value)
//  result   | done_o          | result_o (status, found, found_index, count)
//
// An item is taken when start_i is high and busy_o low; done_o then marks
// its result for a single cycle and the receiver cannot stall it.
// Ignored or full items, and push/insert/pop/erase with nothing to move,
// finish quickly, without moving any entry.
// Insert at p shifts the entries from p up one place and erase at p shifts
// those above p down one place: the store has one write and one read port,
// so entries move one per cycle. Find reads the entries in order from
// index 0 and stops at the first match or after the last entry.
// A new item can be taken in the cycle its result is shown.
// Reset empties the list; stored entries need no clearing as only entries
// below the count are ever read.
module ordered_array_list_engine
  import oale_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF   // 2 to 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides when to shift, scan, store and answer
  oale_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // store, entry count and result register
  oale_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .done_o  (done_o),
    .result_o(result_o)
  );

endmodule
